[design/icdf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icdf_pkg
// Shared types and constants for the inverse cdf table sampler.
// ----------------------------------------------------------------------------
package icdf_pkg;

  localparam int DEF_MAX_POINTS = 128;

  localparam int CFG_W   = 8;
  localparam logic [CFG_W-1:0] RESET_POINTS = 8'd86;

  localparam int IDX_IN_W = 7;
  localparam int E_W      = 16;
  localparam int W_W      = 16;
  localparam int U_W      = 32;
  localparam int T_W      = 23;
  localparam int FRAC_SH  = 16;
  localparam int P_W      = U_W + T_W - FRAC_SH;
  localparam int PROD_W   = U_W + T_W;
  localparam logic [T_W-1:0] TOTAL_MAX = '1;

  localparam int DIV_STEPS = E_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  // in_tdata field offsets
  localparam int IDX_LSB    = 0;
  localparam int ENERGY_LSB = IDX_LSB + IDX_IN_W;
  localparam int WEIGHT_LSB = ENERGY_LSB + E_W;
  localparam int FRAC_LSB   = WEIGHT_LSB + W_W;
  localparam int LIMIT_LSB  = FRAC_LSB + U_W;
  localparam int IN_FIELDS_W = LIMIT_LSB + E_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

  localparam int OUT_TDATA_W = E_W;
  localparam int STATUS_W    = 2;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LIMIT_LOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LOAD_DONE = 2'd3;

  typedef struct packed {
    logic accept;
    logic prep;
    logic rd_mid;
    logic rd_lo;
    logic rd_hi;
    logic step;
    logic cap_lo;
    logic cap_hi;
    logic mul1;
    logic mul2;
    logic sum;
    logic div_step;
    logic finish;
    logic out_load;
  } icdf_cmd_t;

  typedef struct packed {
    logic is_load;
    logic limit_low;
    logic search_done;
    logic use_div;
    logic div_last;
    logic out_free;
  } icdf_sts_t;

endpackage
`default_nettype wire

[design/icdf_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icdf_ctrl
// Sequencer for load and sample transactions: search, interpolate, divide.
// ----------------------------------------------------------------------------
module icdf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire icdf_pkg::icdf_sts_t sts,
  output icdf_pkg::icdf_cmd_t     cmd
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_PREP     = 13'b0000000000010,
    S_SRCH_RD  = 13'b0000000000100,
    S_SRCH_CMP = 13'b0000000001000,
    S_RD_LO    = 13'b0000000010000,
    S_RD_HI    = 13'b0000000100000,
    S_CAP_HI   = 13'b0000001000000,
    S_MUL1     = 13'b0000010000000,
    S_MUL2     = 13'b0000100000000,
    S_SUM      = 13'b0001000000000,
    S_DIV      = 13'b0010000000000,
    S_FIN      = 13'b0100000000000,
    S_OUT      = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.is_load ? S_OUT : S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = sts.limit_low ? S_OUT : S_SRCH_RD;
      end
      S_SRCH_RD: begin
        if (sts.search_done) begin
          cmd.rd_lo = 1'b1;
          state_nxt = S_RD_HI;
        end else begin
          cmd.rd_mid = 1'b1;
          state_nxt  = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        cmd.step  = 1'b1;
        state_nxt = S_SRCH_RD;
      end
      S_RD_LO: begin
        cmd.rd_lo = 1'b1;
        state_nxt = S_RD_HI;
      end
      S_RD_HI: begin
        cmd.cap_lo = 1'b1;
        cmd.rd_hi  = 1'b1;
        state_nxt  = S_CAP_HI;
      end
      S_CAP_HI: begin
        cmd.cap_hi = 1'b1;
        state_nxt  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = sts.use_div ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[design/icdf_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icdf_dpath
// Table memories, running weight sum, search indexes, interpolation and divider.
// ----------------------------------------------------------------------------
module icdf_dpath #(
  parameter int MAX_POINTS = icdf_pkg::DEF_MAX_POINTS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire icdf_pkg::icdf_cmd_t                 cmd,
  output icdf_pkg::icdf_sts_t                      sts,
  input  wire logic                                in_op,
  input  wire logic [icdf_pkg::IN_TDATA_W-1:0]     in_data,
  input  wire logic                                cfg_we,
  input  wire logic [icdf_pkg::CFG_W-1:0]          cfg_data,
  input  wire logic                                out_tready,
  output logic                                     out_tvalid,
  output logic [icdf_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic [icdf_pkg::STATUS_W-1:0]            out_tuser
);

  localparam int IW   = $clog2(MAX_POINTS);
  localparam int E_W  = icdf_pkg::E_W;
  localparam int T_W  = icdf_pkg::T_W;
  localparam int P_W  = icdf_pkg::P_W;
  localparam int SH   = icdf_pkg::FRAC_SH;
  localparam int HI_W = P_W - SH;

  // input fields
  logic [icdf_pkg::IDX_IN_W-1:0] f_idx;
  logic [E_W-1:0]                f_energy;
  logic [icdf_pkg::W_W-1:0]      f_weight;
  logic [icdf_pkg::U_W-1:0]      f_frac;
  logic [E_W-1:0]                f_limit;

  assign f_idx    = in_data[icdf_pkg::IDX_LSB +: icdf_pkg::IDX_IN_W];
  assign f_energy = in_data[icdf_pkg::ENERGY_LSB +: E_W];
  assign f_weight = in_data[icdf_pkg::WEIGHT_LSB +: icdf_pkg::W_W];
  assign f_frac   = in_data[icdf_pkg::FRAC_LSB +: icdf_pkg::U_W];
  assign f_limit  = in_data[icdf_pkg::LIMIT_LSB +: E_W];

  logic [E_W-1:0] energy_mem [MAX_POINTS];
  logic [T_W-1:0] prefix_mem [MAX_POINTS];

  logic [icdf_pkg::CFG_W-1:0] pts_r;
  logic [T_W-1:0]             total_r;
  logic [E_W-1:0]             e0_r;
  logic [icdf_pkg::U_W-1:0]   u_r;
  logic [E_W-1:0]             limit_r;
  logic [P_W-1:0]             p_r;
  logic [IW-1:0]              lo_r, hi_r;
  logic [E_W-1:0]             energy_rd_r;
  logic [T_W-1:0]             prefix_rd_r;
  logic                       rd_last_r;
  logic [T_W-1:0]             v_lo_r, v_hi_r;
  logic [E_W-1:0]             e_lo_r, e_hi_r;
  logic [P_W-1:0]             num_r;
  logic [E_W-1:0]             d_r;
  logic [T_W-1:0]             dv_r;
  logic                       neg_r;
  logic                       use_r;
  logic [HI_W+E_W-1:0]        prodh_r;
  logic [2*E_W-1:0]           prodl_r;
  logic [T_W-1:0]             rem_r;
  logic [E_W-1:0]             q_r;
  logic [icdf_pkg::CNT_W-1:0] cnt_r;
  logic [E_W-1:0]             res_energy_r;
  logic [icdf_pkg::STATUS_W-1:0] res_status_r;
  logic                       out_valid_r;
  logic [E_W-1:0]             out_energy_r;
  logic [icdf_pkg::STATUS_W-1:0] out_status_r;

  // last point index in use, clamped
  logic [IW-1:0] n_last;
  always_comb begin
    if (int'(pts_r) < 2) begin
      n_last = IW'(1);
    end else if (int'(pts_r) > MAX_POINTS) begin
      n_last = IW'(MAX_POINTS - 1);
    end else begin
      n_last = IW'(int'(pts_r) - 1);
    end
  end

  // search index
  logic [IW:0]   lo_hi_sum;
  logic [IW-1:0] mid;
  logic [IW-1:0] span;
  assign lo_hi_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = lo_hi_sum[IW:1];
  assign span      = hi_r - lo_r;

  logic [IW-1:0] rd_addr;
  logic          rd_en;
  assign rd_en   = cmd.rd_mid | cmd.rd_lo | cmd.rd_hi;
  always_comb begin
    if (cmd.rd_mid) begin
      rd_addr = mid;
    end else if (cmd.rd_lo) begin
      rd_addr = lo_r;
    end else begin
      rd_addr = hi_r;
    end
  end

  logic [T_W-1:0] cum_v;
  assign cum_v = rd_last_r ? total_r : prefix_rd_r;

  // load path
  logic          ld_ok;
  logic [IW-1:0] wr_addr;
  logic [T_W:0]  tot_sum;
  logic          ld_we;
  assign ld_ok   = int'(f_idx) < MAX_POINTS;
  assign wr_addr = IW'(f_idx);
  assign tot_sum = {1'b0, total_r} + (T_W+1)'(f_weight);
  assign ld_we   = cmd.accept && (in_op == icdf_pkg::OP_LOAD) && ld_ok;

  always_ff @(posedge clk) begin
    if (ld_we) begin
      energy_mem[wr_addr] <= f_energy;
      prefix_mem[wr_addr] <= (f_idx == '0) ? '0 : total_r;
    end
    if (rd_en) begin
      energy_rd_r <= energy_mem[rd_addr];
      prefix_rd_r <= prefix_mem[rd_addr];
      rd_last_r   <= (rd_addr == n_last);
    end
  end

  // interpolation terms
  logic [P_W-1:0] c_lo, den, num;
  logic           use_c;
  assign c_lo  = {v_lo_r, SH'(0)};
  assign den   = {v_hi_r - v_lo_r, SH'(0)};
  assign num   = p_r - c_lo;
  assign use_c = (v_hi_r > v_lo_r) && (p_r > c_lo);

  logic [icdf_pkg::PROD_W-1:0] p_full;
  assign p_full = u_r * total_r;

  logic [HI_W+E_W:0] x_sum;
  assign x_sum = {1'b0, prodh_r} + (HI_W+E_W+1)'(prodl_r[2*E_W-1:E_W]);

  logic [T_W+1:0] trial;
  assign trial = {1'b0, rem_r, q_r[E_W-1]} - {2'b0, dv_r};

  logic [E_W-1:0] energy_c;
  assign energy_c = !use_r ? e_lo_r : (neg_r ? e_lo_r - q_r : e_lo_r + q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_r       <= icdf_pkg::RESET_POINTS;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        pts_r <= cfg_data;
      end
      if (ld_we) begin
        if (f_idx == '0) begin
          total_r <= T_W'(f_weight);
        end else begin
          total_r <= tot_sum[T_W] ? icdf_pkg::TOTAL_MAX : tot_sum[T_W-1:0];
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (in_op == icdf_pkg::OP_LOAD) begin
        if (f_idx == '0) begin
          e0_r <= f_energy;
        end
        res_energy_r <= '0;
        res_status_r <= icdf_pkg::ST_LOAD_DONE;
      end else begin
        u_r     <= f_frac;
        limit_r <= f_limit;
      end
    end
    if (cmd.prep) begin
      p_r  <= p_full[icdf_pkg::PROD_W-1:SH];
      lo_r <= '0;
      hi_r <= n_last;
      res_energy_r <= limit_r;
      res_status_r <= icdf_pkg::ST_LIMIT_LOW;
    end
    if (cmd.step) begin
      if ({cum_v, SH'(0)} < p_r) begin
        lo_r <= mid;
      end else begin
        hi_r <= mid;
      end
    end
    if (cmd.cap_lo) begin
      v_lo_r <= cum_v;
      e_lo_r <= energy_rd_r;
    end
    if (cmd.cap_hi) begin
      v_hi_r <= cum_v;
      e_hi_r <= energy_rd_r;
    end
    if (cmd.mul1) begin
      num_r <= (num > den) ? den : num;
      dv_r  <= v_hi_r - v_lo_r;
      d_r   <= (e_hi_r >= e_lo_r) ? e_hi_r - e_lo_r : e_lo_r - e_hi_r;
      neg_r <= e_hi_r < e_lo_r;
      use_r <= use_c;
    end
    if (cmd.mul2) begin
      prodh_r <= num_r[P_W-1:SH] * d_r;
      prodl_r <= num_r[SH-1:0] * d_r;
    end
    if (cmd.sum) begin
      rem_r <= x_sum[HI_W+E_W-1:E_W];
      q_r   <= x_sum[E_W-1:0];
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
      if (!trial[T_W+1]) begin
        rem_r <= trial[T_W-1:0];
        q_r   <= {q_r[E_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[T_W-2:0], q_r[E_W-1]};
        q_r   <= {q_r[E_W-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      res_energy_r <= energy_c;
      res_status_r <= (energy_c > limit_r) ? icdf_pkg::ST_REJECTED : icdf_pkg::ST_ACCEPTED;
    end
    if (cmd.out_load) begin
      out_energy_r <= res_energy_r;
      out_status_r <= res_status_r;
    end
  end

  assign sts.is_load     = (in_op == icdf_pkg::OP_LOAD);
  assign sts.limit_low   = limit_r < e0_r;
  assign sts.search_done = span <= IW'(1);
  assign sts.use_div     = use_r;
  assign sts.div_last    = (cnt_r == icdf_pkg::CNT_LAST);
  assign sts.out_free    = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_energy_r;
  assign out_tuser  = out_status_r;

endmodule
`default_nettype wire

[design/inverse_cdf_table_sampler_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// inverse_cdf_table_sampler_unit
// Samples an energy from a loaded spectrum table by inverse transform.
// ----------------------------------------------------------------------------
// load: the table entry is written on accept and the result goes to the output register
// sample: prep, serial bisection over the registered table read, interpolation and the
//   16-step restoring divider; the divider is skipped when no interpolation is
//   needed
// limit below first energy: the search is skipped after prep; one transaction at a time,
//   in_tready rises with out_tvalid, a stalled result holds the input off
// synchronous active-low reset clears control, weight total and register (86 points)
module inverse_cdf_table_sampler_unit #(
  parameter int MAX_POINTS = icdf_pkg::DEF_MAX_POINTS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // point_index, point_energy, point_weight, random_fraction, energy_limit, pad
  input  wire logic [icdf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // operation
  input  wire logic                             in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // sample_energy
  output logic [icdf_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // status
  output logic [icdf_pkg::STATUS_W-1:0]         out_tuser,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [icdf_pkg::CFG_W-1:0]       cfg_data
);

  icdf_pkg::icdf_cmd_t cmd;
  icdf_pkg::icdf_sts_t sts;

  assign cfg_ready = 1'b1;

  icdf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  icdf_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_tuser),
    .in_data    (in_tdata),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
